FILE: rtl/radar_sweep_slice_plotter_assert.svh
// Assertion macros for the plotter RTL.
`ifndef RADAR_SWEEP_SLICE_PLOTTER_ASSERT_SVH
`define RADAR_SWEEP_SLICE_PLOTTER_ASSERT_SVH

// expr must never hold while out of reset
`define RSP_ASSERT_NEVER(lbl, expr) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
	else $error("rsp: forbidden condition seen");

// a at an edge implies b at the same edge
`define RSP_ASSERT_IMPL(lbl, a, b) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (b)) \
	else $error("rsp: implication failed");

`endif

FILE: rtl/rsp_pkg.sv
`default_nettype none
package rsp_pkg;

	localparam int TRIG_FRAC_BITS = 15;
	localparam int ANGLE_MAX      = 180;
	localparam int TRIG_W         = TRIG_FRAC_BITS + 1;
	localparam int PROD_W         = 9 + TRIG_W;

	localparam logic [7:0]  ANG_TOP   = 8'(ANGLE_MAX);
	localparam logic [15:0] COL_GREEN = 16'h07E0;
	localparam logic [15:0] COL_RED   = 16'hF800;
	localparam logic [15:0] COL_BLACK = 16'h0000;

	typedef enum logic [2:0] {
		REG_CYC_PER_CM = 3'd0,
		REG_PX_PER_CM  = 3'd1,
		REG_RADIUS     = 3'd2,
		REG_CENTER_X   = 3'd3,
		REG_CENTER_Y   = 3'd4,
		REG_RED_LEN    = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [15:0] cyc_per_cm;
		logic [3:0]  px_per_cm;
		logic [7:0]  radius;
		logic [8:0]  cx;
		logic [8:0]  cy;
		logic [4:0]  red_len;
	} cfg_t;

	// one slice handed from front to back
	typedef struct packed {
		logic [7:0] dist_px;
		logic       red;
		logic [7:0] ang;
		logic [7:0] servo;
	} job_t;

	typedef struct packed {
		logic signed [10:0] xs;
		logic signed [10:0] ys;
		logic signed [10:0] xe;
		logic signed [10:0] ye;
		logic [15:0]        color;
		logic [7:0]         ang;
		logic [7:0]         servo;
		logic               last;
	} seg_t;

	typedef struct packed {
		logic              neg;
		logic [TRIG_W-1:0] mag;
	} trig_t;

	typedef enum logic [1:0] {F_IDLE, F_DIV, F_DONE} front_state_t;
	typedef enum logic [1:0] {B_IDLE, B_MUL, B_EMIT} back_state_t;

	typedef logic [TRIG_W-1:0] sin_tab_t [0:90];
	typedef logic [7:0] servo_tab_t [0:255];

	// Taylor series sine, first quadrant, evaluated at elaboration
	function automatic logic [TRIG_W-1:0] sine_q1(input int unsigned k);
		logic [63:0] x, x2, term, sum, p;
		x = (64'(k) * 64'd3373259426 + 64'd90) / 64'd180;
		x2 = (x * x) >> 30;
		term = x;
		sum = x;
		for (int n = 1; n <= 7; n++) begin
			p = (term * x2) >> 30;
			case (n)
				1: term = p / 64'd6;
				2: term = p / 64'd20;
				3: term = p / 64'd42;
				4: term = p / 64'd72;
				5: term = p / 64'd110;
				6: term = p / 64'd156;
				default: term = p / 64'd210;
			endcase
			if (n % 2 == 1) sum = sum - term;
			else sum = sum + term;
		end
		return TRIG_W'((sum + (64'd1 << (29 - TRIG_FRAC_BITS))) >> (30 - TRIG_FRAC_BITS));
	endfunction

	function automatic sin_tab_t build_sin_tab();
		sin_tab_t t;
		for (int k = 0; k <= 90; k++) t[k] = sine_q1(k);
		return t;
	endfunction

	function automatic servo_tab_t build_servo_tab();
		servo_tab_t t;
		for (int k = 0; k < 256; k++) t[k] = 8'((k * 255) / ANGLE_MAX);
		return t;
	endfunction

	localparam sin_tab_t   SIN_TAB   = build_sin_tab();
	localparam servo_tab_t SERVO_TAB = build_servo_tab();

	// sine of deg (0..359) by quadrant symmetry
	function automatic trig_t trig_lookup(input logic [8:0] deg);
		trig_t r;
		if (deg <= 9'd90) begin
			r.neg = 1'b0; r.mag = SIN_TAB[7'(deg)];
		end else if (deg <= 9'd180) begin
			r.neg = 1'b0; r.mag = SIN_TAB[7'(9'd180 - deg)];
		end else if (deg <= 9'd270) begin
			r.neg = 1'b1; r.mag = SIN_TAB[7'(deg - 9'd180)];
		end else begin
			r.neg = 1'b1; r.mag = SIN_TAB[7'(9'd360 - deg)];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/rsp_front.sv
`default_nettype none
module rsp_front import rsp_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire cfg_t        cfg,
	input  wire logic        push,
	output logic             full,
	input  wire logic [23:0] raw_echo,
	output logic             jq_push,
	output job_t             jq_data,
	input  wire logic        jq_full
);
	front_state_t state_q, state_d;
	logic [7:0]  ang_q, sweep_angle_q, servo_q;
	logic        sweep_down_q;
	logic [23:0] quo_q;
	logic [15:0] rem_q;
	logic [4:0]  cnt_q;
	logic [16:0] trial;
	logic        ge;
	logic [7:0]  next_ang;
	logic        next_down;
	logic [27:0] px;
	logic        accept;

	assign accept = push && !full;
	assign trial  = {rem_q, quo_q[23]};
	assign ge     = trial >= {1'b0, cfg.cyc_per_cm};
	assign px     = quo_q * cfg.px_per_cm;

	// sweep advance, end angles visited twice
	always_comb begin
		next_ang  = sweep_angle_q;
		next_down = sweep_down_q;
		if (!sweep_down_q) begin
			if (sweep_angle_q >= ANG_TOP) next_down = 1'b1;
			else next_ang = sweep_angle_q + 8'd1;
		end else begin
			if (sweep_angle_q == 8'd0) next_down = 1'b0;
			else next_ang = sweep_angle_q - 8'd1;
		end
	end

	always_comb begin
		state_d = state_q;
		full    = 1'b1;
		jq_push = 1'b0;
		unique case (state_q)
			F_IDLE: begin
				full = 1'b0;
				if (push) state_d = (cfg.cyc_per_cm == 16'd0) ? F_DONE : F_DIV;
			end
			F_DIV: if (cnt_q == 5'd23) state_d = F_DONE;
			F_DONE: begin
				jq_push = !jq_full;
				if (!jq_full) state_d = F_IDLE;
			end
			default: state_d = F_IDLE;
		endcase
	end

	always_comb begin
		jq_data.ang     = ang_q;
		jq_data.servo   = servo_q;
		jq_data.red     = px < 28'(cfg.radius);
		jq_data.dist_px = jq_data.red ? px[7:0] : cfg.radius;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= F_IDLE;
			sweep_angle_q <= 8'd0;
			sweep_down_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				sweep_angle_q <= next_ang;
				sweep_down_q  <= next_down;
			end
		end
	end

	// restoring divider, one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (accept) begin
			ang_q   <= sweep_angle_q;
			servo_q <= SERVO_TAB[next_ang];
			quo_q   <= raw_echo;
			rem_q   <= 16'd0;
			cnt_q   <= 5'd0;
		end else if (state_q == F_DIV) begin
			quo_q <= {quo_q[22:0], ge};
			rem_q <= ge ? 16'(trial - {1'b0, cfg.cyc_per_cm}) : trial[15:0];
			cnt_q <= cnt_q + 5'd1;
		end
	end
endmodule
`default_nettype wire

FILE: rtl/rsp_job_q.sv
`default_nettype none
module rsp_job_q import rsp_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire job_t wdata,
	output logic      full,
	input  wire logic pop,
	output job_t      rdata,
	output logic      empty
);
	job_t       mem_q [0:1];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full  = cnt_q == 2'd2;
	assign empty = cnt_q == 2'd0;
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (pop) rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wdata;
	end
endmodule
`default_nettype wire

FILE: rtl/rsp_back.sv
`default_nettype none
module rsp_back import rsp_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire cfg_t cfg,
	input  wire job_t jq_data,
	input  wire logic jq_empty,
	output logic      jq_pop,
	output seg_t      head,
	output logic      empty,
	input  wire logic pop
);
	back_state_t state_q, state_d;
	job_t        job_q;
	trig_t       cos_q, sin_q;
	logic [2:0]  step_q;
	logic [1:0]  seg_q;
	logic signed [10:0] crd_q [0:5];
	logic [8:0]  dsel;
	trig_t       tsel;
	logic [PROD_W-1:0] prod;
	logic signed [10:0] m, base, crd;
	logic        sub;

	seg_t        oq_q [0:3];
	logic [1:0]  owp_q, orp_q;
	logic [2:0]  ocnt_q;
	logic        ofull, opush, opop;
	seg_t        seg;

	assign ofull = ocnt_q == 3'd4;
	assign empty = ocnt_q == 3'd0;
	assign opop  = pop && !empty;
	assign head  = oq_q[orp_q];

	// steps: x/y at dist, at dist+red, at radius
	always_comb begin
		case (step_q[2:1])
			2'd0:    dsel = {1'b0, job_q.dist_px};
			2'd1:    dsel = {1'b0, job_q.dist_px} + 9'(cfg.red_len);
			default: dsel = {1'b0, cfg.radius};
		endcase
		tsel = step_q[0] ? sin_q : cos_q;
		prod = dsel * tsel.mag;
		m    = 11'(prod >> TRIG_FRAC_BITS);
		base = step_q[0] ? $signed({2'b00, cfg.cy}) : $signed({2'b00, cfg.cx});
		sub  = step_q[0] ? !tsel.neg : tsel.neg;
		crd  = sub ? base - m : base + m;
	end

	always_comb begin
		seg.ang   = job_q.ang;
		seg.servo = job_q.servo;
		case (seg_q)
			2'd0: begin
				seg.xs = $signed({2'b00, cfg.cx}); seg.ys = $signed({2'b00, cfg.cy});
				seg.xe = crd_q[0]; seg.ye = crd_q[1];
				seg.color = COL_GREEN; seg.last = 1'b0;
			end
			2'd1: begin
				seg.xs = crd_q[0]; seg.ys = crd_q[1];
				seg.xe = crd_q[2]; seg.ye = crd_q[3];
				seg.color = COL_RED; seg.last = 1'b0;
			end
			default: begin
				seg.xs = job_q.red ? crd_q[2] : crd_q[0];
				seg.ys = job_q.red ? crd_q[3] : crd_q[1];
				seg.xe = crd_q[4]; seg.ye = crd_q[5];
				seg.color = COL_BLACK; seg.last = 1'b1;
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		jq_pop  = 1'b0;
		opush   = 1'b0;
		unique case (state_q)
			B_IDLE: if (!jq_empty) begin
				jq_pop  = 1'b1;
				state_d = B_MUL;
			end
			B_MUL: if (step_q == 3'd5) state_d = B_EMIT;
			B_EMIT: begin
				opush = !ofull;
				if (!ofull && seg_q == 2'd2) state_d = B_IDLE;
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			owp_q   <= 2'd0;
			orp_q   <= 2'd0;
			ocnt_q  <= 3'd0;
		end else begin
			state_q <= state_d;
			if (opush) owp_q <= owp_q + 2'd1;
			if (opop) orp_q <= orp_q + 2'd1;
			ocnt_q <= ocnt_q + 3'(opush) - 3'(opop);
		end
	end

	always_ff @(posedge clk) begin
		if (jq_pop) begin
			job_q  <= jq_data;
			cos_q  <= trig_lookup(9'(jq_data.ang) + 9'd90);
			sin_q  <= trig_lookup(9'(jq_data.ang));
			step_q <= 3'd0;
			seg_q  <= 2'd0;
		end else if (state_q == B_MUL) begin
			crd_q[step_q] <= crd;
			step_q <= step_q + 3'd1;
		end else if (opush) begin
			seg_q <= (seg_q == 2'd0 && !job_q.red) ? 2'd2 : seg_q + 2'd1;
		end
		if (opush) oq_q[owp_q] <= seg;
	end

`include "radar_sweep_slice_plotter_assert.svh"
	`RSP_ASSERT_NEVER(a_oq_overflow, ocnt_q > 3'd4)
	`RSP_ASSERT_IMPL(a_pop_only_idle, jq_pop, state_q == B_IDLE && !jq_empty)
	`RSP_ASSERT_IMPL(a_red_needs_flag, opush && seg.color == COL_RED, job_q.red)
endmodule
`default_nettype wire

FILE: rtl/radar_sweep_slice_plotter.sv
// Radar sweep slice plotter.
// Input queue side: raw_echo is taken when push is high and full is low; one
// word is one echo time for the current sweep angle (0..180..0, ends twice).
// Result queue side: while empty is low the oldest segment word sits on
// x_start..last; pop with empty low takes it. Each echo yields three segments
// (green, red, black) or two when the object is at or past the radius;
// last marks the final one of a slice.
// Config: cfg_we writes cfg_data into register cfg_index at once; write only
// while idle. Unknown indexes are ignored.
// Flow: the front loads the echo into a bit-serial divider, divides, then
// hands the slice to the job queue, waiting while it is full; with
// cycles_per_cm 0 the divide is skipped. Full stays high until the hand-off.
// The back pops a job, runs 6 multiply steps and emits two or three segment
// words per slice; it runs alongside the next division through a two-entry
// job queue.
// Reset clears the sweep to angle 0 upward, empties all queues and loads the
// default registers. A stalled receiver fills the 4-word result queue, then
// the job queue, and finally holds full high.
`default_nettype none
module radar_sweep_slice_plotter import rsp_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_we,
	input  wire logic [2:0]   cfg_index,
	input  wire logic [15:0]  cfg_data,
	input  wire logic         push,
	output logic              full,
	input  wire logic [23:0]  raw_echo,
	output logic              empty,
	input  wire logic         pop,
	output logic signed [10:0] x_start,
	output logic signed [10:0] y_start,
	output logic signed [10:0] x_end,
	output logic signed [10:0] y_end,
	output logic [15:0]       color_rgb565,
	output logic [7:0]        slice_angle,
	output logic [7:0]        servo_next,
	output logic              last
);
	cfg_t cfg_q;
	logic jq_push, jq_full, jq_pop, jq_empty;
	job_t jq_wdata, jq_rdata;
	seg_t head;

	// register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cyc_per_cm <= 16'd2900;
			cfg_q.px_per_cm  <= 4'd2;
			cfg_q.radius     <= 8'd220;
			cfg_q.cx         <= 9'd160;
			cfg_q.cy         <= 9'd239;
			cfg_q.red_len    <= 5'd5;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CYC_PER_CM: cfg_q.cyc_per_cm <= cfg_data;
				REG_PX_PER_CM:  cfg_q.px_per_cm  <= cfg_data[3:0];
				REG_RADIUS:     cfg_q.radius     <= cfg_data[7:0];
				REG_CENTER_X:   cfg_q.cx         <= cfg_data[8:0];
				REG_CENTER_Y:   cfg_q.cy         <= cfg_data[8:0];
				REG_RED_LEN:    cfg_q.red_len    <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	// front: sweep tracking, divide, scale and clamp
	rsp_front u_front (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q),
		.push(push), .full(full), .raw_echo(raw_echo),
		.jq_push(jq_push), .jq_data(jq_wdata), .jq_full(jq_full)
	);

	rsp_job_q u_jq (
		.clk(clk), .arst_n(arst_n),
		.push(jq_push), .wdata(jq_wdata), .full(jq_full),
		.pop(jq_pop), .rdata(jq_rdata), .empty(jq_empty)
	);

	// back: trig, endpoints, segment words
	rsp_back u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q),
		.jq_data(jq_rdata), .jq_empty(jq_empty), .jq_pop(jq_pop),
		.head(head), .empty(empty), .pop(pop)
	);

	assign x_start      = head.xs;
	assign y_start      = head.ys;
	assign x_end        = head.xe;
	assign y_end        = head.ye;
	assign color_rgb565 = head.color;
	assign slice_angle  = head.ang;
	assign servo_next   = head.servo;
	assign last         = head.last;
endmodule
`default_nettype wire
